/* sv/rgco_pkg.sv */
// ----------------------------------------------------------------------------
// rgco_pkg: shared types and constants for the risk grid cost overlay
// Holds the register map, the configuration bundle and the records that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rgco_pkg;

   // Map and grid extents in cells.
   localparam int unsigned MAP_DIM  = 4096;
   localparam int unsigned GRID_DIM = 1024;

   // Cost codes.
   localparam logic [7:0] MAX_RISK_COST = 8'd252;
   localparam logic [7:0] UNKNOWN_COST  = 8'd255;
   localparam logic [7:0] MIN_RISK_COST = 8'd1;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 26;

   // Register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_COS_YAW    = 3'd0,
      REG_SIN_YAW    = 3'd1,
      REG_ORIGIN_X   = 3'd2,
      REG_ORIGIN_Y   = 3'd3,
      REG_CELL_RATIO = 3'd4,
      REG_COST_GAIN  = 3'd5,
      REG_WINDOW_MIN = 3'd6,
      REG_WINDOW_MAX = 3'd7
   } reg_index_type;

   // Register reset values.
   localparam logic [15:0] COS_YAW_RESET    = 16'd16384;
   localparam logic [15:0] SIN_YAW_RESET    = 16'd0;
   localparam logic [20:0] ORIGIN_RESET     = 21'd0;
   localparam logic [15:0] CELL_RATIO_RESET = 16'd256;
   localparam logic [11:0] COST_GAIN_RESET  = 12'd645;
   localparam logic [25:0] WINDOW_MIN_RESET = 26'd0;
   localparam logic [25:0] WINDOW_MAX_RESET = 26'd33558528;

   // Configuration bundle seen by every stage.
   typedef struct packed {
      logic [15:0] cos_yaw;
      logic [15:0] sin_yaw;
      logic [20:0] origin_x_cells;
      logic [20:0] origin_y_cells;
      logic [15:0] cell_ratio;
      logic [11:0] cost_gain;
      logic [25:0] window_min;
      logic [25:0] window_max;
   } cfg_type;

   // Input item.
   typedef struct packed {
      logic [7:0] existing_cost;
      logic [7:0] risk_value;
      logic [9:0] grid_row;
      logic [9:0] grid_col;
   } item_type;

   // After scaling: cell centre times ratio, clamped cost.
   typedef struct packed {
      logic        ok;
      logic [26:0] a;
      logic [26:0] b;
      logic [7:0]  risk_cost;
      logic [7:0]  existing_cost;
   } s1_type;

   // After rotation products (units of 2^-23 map cells).
   typedef struct packed {
      logic               ok;
      logic signed [43:0] a_cos;
      logic signed [43:0] b_sin;
      logic signed [43:0] a_sin;
      logic signed [43:0] b_cos;
      logic [7:0]         risk_cost;
      logic [7:0]         existing_cost;
   } s2_type;

   // After translation and flooring.
   typedef struct packed {
      logic        in_map;
      logic [11:0] fx;
      logic [11:0] fy;
      logic [7:0]  risk_cost;
      logic [7:0]  existing_cost;
   } s3_type;

   // Result item.
   typedef struct packed {
      logic        write_cost;
      logic [7:0]  merged_cost;
      logic [11:0] map_row;
      logic [11:0] map_col;
   } result_type;

endpackage

`default_nettype wire

/* sv/rgco_scale.sv */
// ----------------------------------------------------------------------------
// rgco_scale: first pipeline stage
// Forms the cell centre in half cells, scales it by the cell ratio and
// derives the clamped new cost from the risk value and the gain.
// ----------------------------------------------------------------------------
`default_nettype none

module rgco_scale import rgco_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output s1_type        out_data
);

   logic        valid_ff;
   s1_type      data_ff;
   s1_type      data_in;
   logic [10:0] u;
   logic [10:0] v;
   logic [18:0] cost_raw;
   logic        risk_pos;
   logic        index_ok;

   // The stage moves when it is empty or its content is taken downstream.
   assign in_ready = !valid_ff || out_ready;

   // Centre coordinates and scaling.
   always_comb begin
      u        = {in_data.grid_col, 1'b1};
      v        = {in_data.grid_row, 1'b1};
      risk_pos = !in_data.risk_value[7] && (in_data.risk_value[6:0] != 7'd0);
      index_ok = ({22'd0, in_data.grid_col} < 32'(GRID_DIM)) &&
                 ({22'd0, in_data.grid_row} < 32'(GRID_DIM));
      cost_raw = {12'd0, in_data.risk_value[6:0]} * {7'd0, cfg.cost_gain};

      data_in.ok            = risk_pos && index_ok;
      data_in.a             = {16'd0, u} * {11'd0, cfg.cell_ratio};
      data_in.b             = {16'd0, v} * {11'd0, cfg.cell_ratio};
      data_in.existing_cost = in_data.existing_cost;
      // Clamp the floored cost to the range of risk costs.
      if (cost_raw[18:8] > {3'd0, MAX_RISK_COST}) begin
         data_in.risk_cost = MAX_RISK_COST;
      end else if (cost_raw[18:8] == 11'd0) begin
         data_in.risk_cost = MIN_RISK_COST;
      end else begin
         data_in.risk_cost = cost_raw[15:8];
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/rgco_rotate.sv */
// ----------------------------------------------------------------------------
// rgco_rotate: second pipeline stage
// Multiplies the scaled centre by the cosine and sine of the grid rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module rgco_rotate import rgco_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire s1_type  in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output s2_type       out_data
);

   logic               valid_ff;
   s2_type             data_ff;
   logic signed [27:0] a_s;
   logic signed [27:0] b_s;
   logic signed [15:0] cs;
   logic signed [15:0] sn;

   assign in_ready = !valid_ff || out_ready;

   // Signed operands for the four rotation products.
   assign a_s = $signed({1'b0, in_data.a});
   assign b_s = $signed({1'b0, in_data.b});
   assign cs  = $signed(cfg.cos_yaw);
   assign sn  = $signed(cfg.sin_yaw);

   // Stage register with the products.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff.ok            <= in_data.ok;
         data_ff.a_cos         <= a_s * cs;
         data_ff.b_sin         <= b_s * sn;
         data_ff.a_sin         <= a_s * sn;
         data_ff.b_cos         <= b_s * cs;
         data_ff.risk_cost     <= in_data.risk_cost;
         data_ff.existing_cost <= in_data.existing_cost;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/rgco_place.sv */
// ----------------------------------------------------------------------------
// rgco_place: third pipeline stage
// Adds the origin, floors to map cells and checks the map bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module rgco_place import rgco_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire s2_type  in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output s3_type       out_data
);

   logic        valid_ff;
   s3_type      data_ff;
   s3_type      data_in;
   logic [45:0] ox_ext;
   logic [45:0] oy_ext;
   logic [45:0] sx;
   logic [45:0] sy;
   logic        x_ok;
   logic        y_ok;

   assign in_ready = !valid_ff || out_ready;

   // Two's complement sums in 46 bits; the origin moves to 2^-23 units.
   always_comb begin
      ox_ext = {{10{cfg.origin_x_cells[20]}}, cfg.origin_x_cells, 15'd0};
      oy_ext = {{10{cfg.origin_y_cells[20]}}, cfg.origin_y_cells, 15'd0};
      sx = ox_ext + {{2{in_data.a_cos[43]}}, in_data.a_cos}
                  - {{2{in_data.b_sin[43]}}, in_data.b_sin};
      sy = oy_ext + {{2{in_data.a_sin[43]}}, in_data.a_sin}
                  + {{2{in_data.b_cos[43]}}, in_data.b_cos};
      // Non-negative and floored below the map extent.
      x_ok = !sx[45] && ({9'd0, sx[45:23]} < 32'(MAP_DIM));
      y_ok = !sy[45] && ({9'd0, sy[45:23]} < 32'(MAP_DIM));

      data_in.in_map        = in_data.ok && x_ok && y_ok;
      data_in.fx            = sx[34:23];
      data_in.fy            = sy[34:23];
      data_in.risk_cost     = in_data.risk_cost;
      data_in.existing_cost = in_data.existing_cost;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/rgco_merge.sv */
// ----------------------------------------------------------------------------
// rgco_merge: fourth pipeline stage and output register
// Applies the update window and merges the new cost with the existing one.
// ----------------------------------------------------------------------------
`default_nettype none

module rgco_merge import rgco_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire s3_type  in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output result_type   out_data
);

   logic        valid_ff;
   result_type  data_ff;
   result_type  data_in;
   logic [12:0] min_col;
   logic [12:0] min_row;
   logic [12:0] max_col;
   logic [12:0] max_row;
   logic        win_ok;
   logic        do_write;

   assign in_ready = !valid_ff || out_ready;

   // Window test on 13-bit corner fields and the cost merge.
   always_comb begin
      min_col = cfg.window_min[12:0];
      min_row = cfg.window_min[25:13];
      max_col = cfg.window_max[12:0];
      max_row = cfg.window_max[25:13];
      win_ok  = ({1'b0, in_data.fx} >= min_col) && ({1'b0, in_data.fx} < max_col) &&
                ({1'b0, in_data.fy} >= min_row) && ({1'b0, in_data.fy} < max_row);
      do_write = in_data.in_map && win_ok &&
                 ((in_data.existing_cost == UNKNOWN_COST) ||
                  (in_data.risk_cost > in_data.existing_cost));

      data_in.write_cost  = do_write;
      data_in.map_col     = do_write ? in_data.fx : 12'd0;
      data_in.map_row     = do_write ? in_data.fy : 12'd0;
      data_in.merged_cost = do_write ? in_data.risk_cost : in_data.existing_cost;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/risk_grid_cost_overlay.sv */
// ----------------------------------------------------------------------------
// risk_grid_cost_overlay: merges risk-grid cells into a target cost map
// Throughput: one cell per clock while rsp_tready does not stall the output,
// through four registered stages
// (scale, rotate products, translate and floor, window and merge).
// Reset clears every stage valid bit and returns all configuration registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module risk_grid_cost_overlay import rgco_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration write port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // grid_col[9:0], grid_row[19:10], risk_value[27:20], existing_cost[35:28]
   input  wire logic [39:0]           req_tdata,
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // map_col[11:0], map_row[23:12], merged_cost[31:24]
   output logic [31:0]                rsp_tdata,
   // write_cost[0]
   output logic [0:0]                 rsp_tuser
);

   cfg_type    cfg_ff;
   item_type   req_item;
   s1_type     s1_data;
   s2_type     s2_data;
   s3_type     s3_data;
   result_type rsp_item;
   logic       s1_valid;
   logic       s1_ready;
   logic       s2_valid;
   logic       s2_ready;
   logic       s3_valid;
   logic       s3_ready;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_yaw        <= COS_YAW_RESET;
         cfg_ff.sin_yaw        <= SIN_YAW_RESET;
         cfg_ff.origin_x_cells <= ORIGIN_RESET;
         cfg_ff.origin_y_cells <= ORIGIN_RESET;
         cfg_ff.cell_ratio     <= CELL_RATIO_RESET;
         cfg_ff.cost_gain      <= COST_GAIN_RESET;
         cfg_ff.window_min     <= WINDOW_MIN_RESET;
         cfg_ff.window_max     <= WINDOW_MAX_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_COS_YAW:    cfg_ff.cos_yaw        <= csr_wdata[15:0];
            REG_SIN_YAW:    cfg_ff.sin_yaw        <= csr_wdata[15:0];
            REG_ORIGIN_X:   cfg_ff.origin_x_cells <= csr_wdata[20:0];
            REG_ORIGIN_Y:   cfg_ff.origin_y_cells <= csr_wdata[20:0];
            REG_CELL_RATIO: cfg_ff.cell_ratio     <= csr_wdata[15:0];
            REG_COST_GAIN:  cfg_ff.cost_gain      <= csr_wdata[11:0];
            REG_WINDOW_MIN: cfg_ff.window_min     <= csr_wdata[25:0];
            REG_WINDOW_MAX: cfg_ff.window_max     <= csr_wdata[25:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack the request transaction.
   assign req_item.grid_col      = req_tdata[9:0];
   assign req_item.grid_row      = req_tdata[19:10];
   assign req_item.risk_value    = req_tdata[27:20];
   assign req_item.existing_cost = req_tdata[35:28];

   // Pipeline stages.
   rgco_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_item),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   rgco_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rgco_place u_place (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   rgco_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item)
   );

   // Pack the response transaction.
   assign rsp_tdata = {rsp_item.merged_cost, rsp_item.map_row, rsp_item.map_col};
   assign rsp_tuser = rsp_item.write_cost;

   // A written cost is always a valid risk cost.
   a_write_cost_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[31:24] != 8'd0) &&
                                     (rsp_tdata[31:24] <= MAX_RISK_COST))
      else $error("written cost outside the risk cost range");

   // Without a write the target coordinates stay zero.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[23:0] == 24'd0))
      else $error("map coordinates set without a write");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // With an empty first stage the pipeline never refuses a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid |-> req_tready)
      else $error("request refused with an empty first stage");

endmodule

`default_nettype wire

/* tb/cost_overlay_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cost_overlay_checker: prediction and comparison for the cost overlay
// Watches the configuration port and both streams. It keeps its own copy of
// the registers. For every request transaction it predicts the merged map
// write, and it compares each response transaction against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------

module cost_overlay_checker import rgco_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // grid_col[9:0], grid_row[19:10], risk_value[27:20], existing_cost[35:28]
   input  wire logic [39:0]           req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // map_col[11:0], map_row[23:12], merged_cost[31:24]
   input  wire logic [31:0]           rsp_tdata,
   // write_cost[0]
   input  wire logic [0:0]            rsp_tuser,
   output int                         outstanding,
   output int                         mismatches
);

   localparam cfg_type CFG_RESET = cfg_type'{COS_YAW_RESET, SIN_YAW_RESET, ORIGIN_RESET,
      ORIGIN_RESET, CELL_RATIO_RESET, COST_GAIN_RESET, WINDOW_MIN_RESET, WINDOW_MAX_RESET};

   cfg_type    shadow_cfg = CFG_RESET;
   result_type predicted_merges[$];

   initial begin
      outstanding = 0;
      mismatches  = 0;
   end

   // Project one grid cell into the map and merge its cost with the old one.
   function automatic result_type overlay_cell(input cfg_type c, input logic [39:0] d);
      logic        [9:0] col;
      logic        [9:0] row;
      logic signed [7:0] risk;
      logic        [7:0] prev;
      longint            a, b, cs, sn, ox, oy, sx, sy, fx, fy, nc;
      longint            min_col, min_row, max_col, max_row;
      result_type        r;
      col     = d[9:0];
      row     = d[19:10];
      risk    = d[27:20];
      prev    = d[35:28];
      r       = '0;
      r.merged_cost = prev;
      min_col = longint'(c.window_min[12:0]);
      min_row = longint'(c.window_min[25:13]);
      max_col = longint'(c.window_max[12:0]);
      max_row = longint'(c.window_max[25:13]);
      if (risk > 0) begin
         // Cell centre in half cells, times the Q8.8 ratio, then the Q1.14 rotation.
         a  = (2 * longint'(col) + 1) * longint'(c.cell_ratio);
         b  = (2 * longint'(row) + 1) * longint'(c.cell_ratio);
         cs = longint'($signed(c.cos_yaw));
         sn = longint'($signed(c.sin_yaw));
         ox = longint'($signed(c.origin_x_cells));
         oy = longint'($signed(c.origin_y_cells));
         sx = ox * 32768 + a * cs - b * sn;
         sy = oy * 32768 + a * sn + b * cs;
         if (sx >= 0 && sy >= 0) begin
            fx = sx >>> 23;
            fy = sy >>> 23;
            if (fx < longint'(MAP_DIM) && fy < longint'(MAP_DIM) &&
                fx >= min_col && fx < max_col && fy >= min_row && fy < max_row) begin
               nc = (longint'(risk) * longint'(c.cost_gain)) >>> 8;
               if (nc > longint'(MAX_RISK_COST)) nc = longint'(MAX_RISK_COST);
               if (nc < longint'(MIN_RISK_COST)) nc = longint'(MIN_RISK_COST);
               if (prev == UNKNOWN_COST || nc > longint'(prev)) begin
                  r.write_cost  = 1'b1;
                  r.map_col     = fx[11:0];
                  r.map_row     = fy[11:0];
                  r.merged_cost = nc[7:0];
               end
            end
         end
      end
      return r;
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   // Track configuration, queue predictions and check responses.
   always @(posedge clock) begin
      result_type got, want;
      int         delta;
      delta = 0;
      if (reset) begin
         shadow_cfg = CFG_RESET;
         predicted_merges.delete();
         outstanding <= 0;
      end else begin
         // Predict with the settings in force before any write at this edge.
         if (req_tvalid && req_tready) begin
            predicted_merges.push_back(overlay_cell(shadow_cfg, req_tdata));
            delta++;
         end
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_COS_YAW:    shadow_cfg.cos_yaw        = csr_wdata[15:0];
               REG_SIN_YAW:    shadow_cfg.sin_yaw        = csr_wdata[15:0];
               REG_ORIGIN_X:   shadow_cfg.origin_x_cells = csr_wdata[20:0];
               REG_ORIGIN_Y:   shadow_cfg.origin_y_cells = csr_wdata[20:0];
               REG_CELL_RATIO: shadow_cfg.cell_ratio     = csr_wdata[15:0];
               REG_COST_GAIN:  shadow_cfg.cost_gain      = csr_wdata[11:0];
               REG_WINDOW_MIN: shadow_cfg.window_min     = csr_wdata[25:0];
               REG_WINDOW_MAX: shadow_cfg.window_max     = csr_wdata[25:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'({rsp_tuser, rsp_tdata});
            if (predicted_merges.size() == 0) begin
               mismatches++;
               $display("%0t: response expected none, actual %h", $time, got);
            end else begin
               want = predicted_merges.pop_front();
               delta--;
               if (got.map_col != want.map_col)
                  note_mismatch("map_col", want.map_col, got.map_col);
               if (got.map_row != want.map_row)
                  note_mismatch("map_row", want.map_row, got.map_row);
               if (got.merged_cost != want.merged_cost)
                  note_mismatch("merged_cost", want.merged_cost, got.merged_cost);
               if (got.write_cost != want.write_cost)
                  note_mismatch("write_cost", want.write_cost, got.write_cost);
            end
         end
         outstanding <= outstanding + delta;
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the risk grid cost overlay
// Runs a directed set of cells at the reset settings, then random cells over
// a series of register settings with varying idle patterns on both streams.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------

module tb;
   import rgco_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int SEGMENTS     = 13;
   localparam int SEGMENT_LEN  = 150;
   localparam int DRAIN_CYCLES = 8;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic [0:0]            rsp_tuser;

   int outstanding;
   int mismatches;
   int cycle_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   risk_grid_cost_overlay DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cost_overlay_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver stalls at random according to the current idle percentage.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [25:0] window_corner(input int row, input int col);
      return 26'(row * 8192 + col);
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [25:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Offer one cell and hold it until the block takes the transaction.
   task automatic send_cell(input logic [9:0] col, input logic [9:0] row,
                            input logic [7:0] risk, input logic [7:0] existing);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, existing, risk, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted response has come back.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Program all registers for one geometry and cost setting.
   task automatic apply_setting(input int k);
      logic [15:0] cos_v, sin_v, ratio_v;
      logic [20:0] ox_v, oy_v;
      logic [11:0] gain_v;
      logic [25:0] wmin_v, wmax_v;
      cos_v   = COS_YAW_RESET;
      sin_v   = SIN_YAW_RESET;
      ox_v    = ORIGIN_RESET;
      oy_v    = ORIGIN_RESET;
      ratio_v = CELL_RATIO_RESET;
      gain_v  = COST_GAIN_RESET;
      wmin_v  = WINDOW_MIN_RESET;
      wmax_v  = WINDOW_MAX_RESET;
      case (k)
         // Quarter turn, doubled scale, maximum gain, partial window.
         1: begin
            cos_v   = 16'd0;
            sin_v   = 16'd16384;
            ratio_v = 16'd512;
            ox_v    = 21'(2048 * 256);
            gain_v  = 12'd4095;
            wmin_v  = window_corner(100, 200);
            wmax_v  = window_corner(3000, 4000);
         end
         // Cosine beyond its range, largest origin, zero gain.
         2: begin
            cos_v   = 16'(-32768);
            sin_v   = 16'd16384;
            ratio_v = 16'd64;
            ox_v    = 21'(1048575);
            oy_v    = 21'(1000 * 256);
            gain_v  = 12'd0;
         end
         // Zero ratio folds every cell onto one map cell; window of one cell.
         3: begin
            ratio_v = 16'd0;
            ox_v    = 21'(300 * 256);
            oy_v    = 21'(700 * 256);
            gain_v  = 12'd1;
            wmin_v  = window_corner(700, 300);
            wmax_v  = window_corner(701, 301);
         end
         // Largest ratio with the most negative origin.
         4: begin
            ratio_v = 16'd65535;
            ox_v    = 21'(-1048576);
            gain_v  = 12'd2000;
         end
         // Inverted window drops everything.
         5: begin
            oy_v    = 21'(1048575);
            gain_v  = 12'd2048;
            wmin_v  = WINDOW_MAX_RESET;
            wmax_v  = 26'd0;
         end
         // Eighth turn around a shifted origin.
         6: begin
            cos_v   = 16'd11585;
            sin_v   = 16'd11585;
            ox_v    = 21'(1500 * 256);
            gain_v  = 12'd300;
         end
         // Negative quarter turn with a band of rows.
         7: begin
            cos_v   = 16'd0;
            sin_v   = 16'(-16384);
            oy_v    = 21'(2000 * 256);
            gain_v  = 12'd1000;
            wmin_v  = window_corner(1500, 0);
            wmax_v  = window_corner(2100, 4096);
         end
         default: ;
      endcase
      write_reg(REG_COS_YAW,    26'(cos_v));
      write_reg(REG_SIN_YAW,    26'(sin_v));
      write_reg(REG_ORIGIN_X,   26'(ox_v));
      write_reg(REG_ORIGIN_Y,   26'(oy_v));
      write_reg(REG_CELL_RATIO, 26'(ratio_v));
      write_reg(REG_COST_GAIN,  26'(gain_v));
      write_reg(REG_WINDOW_MIN, wmin_v);
      write_reg(REG_WINDOW_MAX, wmax_v);
      csr_we <= 1'b0;
   endtask

   // Main stimulus sequence.
   initial begin
      logic [7:0] risk;
      logic [7:0] existing;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cells at the reset settings: field extremes and merge rules.
      tx_idle_pct = 21;
      rx_idle_pct = 74;
      send_cell(10'd0,    10'd0,    8'd1,   8'd0);
      send_cell(10'd1023, 10'd1023, 8'd127, 8'd255);
      send_cell(10'd1023, 10'd0,    8'h80,  8'd255);
      send_cell(10'd0,    10'd1023, 8'd0,   8'd255);
      send_cell(10'd5,    10'd7,    8'hFF,  8'd0);
      send_cell(10'd5,    10'd7,    8'd100, 8'd250);
      send_cell(10'd5,    10'd7,    8'd100, 8'd251);
      send_cell(10'd5,    10'd7,    8'd100, 8'd252);
      send_cell(10'd5,    10'd7,    8'd127, 8'd252);
      send_cell(10'd5,    10'd7,    8'd127, 8'd251);
      send_cell(10'd9,    10'd9,    8'd127, 8'd254);
      send_cell(10'd9,    10'd9,    8'd1,   8'd1);
      send_cell(10'd9,    10'd9,    8'd1,   8'd2);
      send_cell(10'd682,  10'd341,  8'd64,  8'd0);
      send_cell(10'd341,  10'd682,  8'd42,  8'd128);
      send_cell(10'd512,  10'd512,  8'd127, 8'd0);
      send_cell(10'd1023, 10'd1023, 8'd127, 8'd0);
      send_cell(10'd1,    10'd2,    8'd101, 8'd255);
      send_cell(10'd1022, 10'd1,    8'd2,   8'd3);
      send_cell(10'd3,    10'd1022, 8'd50,  8'd125);
      drain_pipeline();

      // Random cells, one register setting per segment.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         apply_setting(seg % 8);
         if (seg < 4) begin
            tx_idle_pct = 21;
            rx_idle_pct = 74;
         end else if (seg < 8) begin
            tx_idle_pct = 74;
            rx_idle_pct = 21;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (int n = 0; n < SEGMENT_LEN; n++) begin
            // Hold off once mid-stream until the pipeline is empty.
            if (seg == 10 && n == SEGMENT_LEN / 2) drain_pipeline();
            // Mostly positive risk, with a share of arbitrary values.
            if ($urandom_range(0, 3) != 0) risk = 8'($urandom_range(1, 127));
            else risk = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) existing = UNKNOWN_COST;
            else existing = 8'($urandom_range(0, 255));
            send_cell(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      risk, existing);
         end
         drain_pipeline();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
